>>> hw/rtl/wplc_pkg.sv
package wplc_pkg;

    localparam int CordicIterations = 16;
    localparam int AngW = 28;
    localparam logic signed [AngW-1:0] AngPi = 28'sd52707179;

    typedef enum logic [1:0] {
        CMD_SAMPLE  = 2'd0,
        CMD_RESTART = 2'd1,
        CMD_CANCEL  = 2'd2,
        CMD_UNUSED  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        GOAL_RUNNING  = 2'd0,
        GOAL_DONE     = 2'd1,
        GOAL_CANCELED = 2'd2,
        GOAL_SPARE    = 2'd3
    } goal_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQRT,
        ST_CORDIC,
        ST_MUL,
        ST_FINISH,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        SQ_IDLE,
        SQ_MUL,
        SQ_ROOT,
        SQ_RND
    } sq_state_t;

    typedef enum logic [2:0] {
        REG_LIN_GAIN  = 3'd0,
        REG_MAX_LIN   = 3'd1,
        REG_ANG_GAIN  = 3'd2,
        REG_ANG_LIMIT = 3'd3,
        REG_ARRIVE    = 3'd4,
        REG_LEAVE     = 3'd5,
        REG_RETURN    = 3'd6,
        REG_NONE      = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [15:0] wp_dx;
        logic signed [15:0] wp_dy;
        logic signed [15:0] start_dx;
        logic signed [15:0] start_dy;
    } in_item_t;

    typedef struct packed {
        logic [15:0]        waypoint_distance;
        logic [14:0]        fwd_rate;
        logic signed [15:0] turn_rate;
        logic               at_waypoint;
        logic               start_left;
        logic [1:0]         goal_status;
    } out_item_t;

    typedef struct packed {
        logic [11:0] linear_gain;
        logic [14:0] fwd_rate_cap;
        logic [11:0] angular_gain;
        logic [14:0] angular_limit;
        logic [14:0] arrive_radius;
        logic [14:0] leave_radius;
        logic [14:0] return_radius;
    } cfg_t;

    function automatic logic [AngW-1:0] atan_entry(input logic [4:0] i);
        logic [AngW-1:0] r;
        unique case (i)
            5'd0:    r = 28'd13176795;
            5'd1:    r = 28'd7778716;
            5'd2:    r = 28'd4110060;
            5'd3:    r = 28'd2086331;
            5'd4:    r = 28'd1047214;
            5'd5:    r = 28'd524117;
            5'd6:    r = 28'd262123;
            5'd7:    r = 28'd131069;
            default: r = 28'd65536 >> (i - 5'd8);
        endcase
        return r;
    endfunction

endpackage

>>> hw/rtl/waypoint_pursuit_lap_controller.sv
// control sample: two magnitude passes (start, 16 square steps, 16 root steps, rounding), cordic
// beside the first, then bearing check, gain multiply, wrap-up and output; restart, cancel and
// unused codes go straight to output
// throughput: one item at a time, no new input accepted until the result is taken
// reset: gains and radii to defaults, lap flag cleared, goal running
module waypoint_pursuit_lap_controller
    import wplc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    state_t    st_reg, st_next;
    cfg_t      cfg_reg, cfg_next;
    logic      flag_reg, flag_next;
    goal_t     goal_reg, goal_next;
    in_item_t  item_reg, item_next;
    out_item_t res_reg, res_next;
    logic      phase_reg, phase_next;
    logic      kick_reg, kick_next;
    logic [16:0] wdist_reg, wdist_next, sdist_reg, sdist_next;
    logic signed [AngW-1:0] ang_reg, ang_next;
    logic signed [40:0] prod_reg, prod_next;

    logic        sq_start, sq_done, co_start, co_done, mu_start, mu_done;
    logic [16:0] sq_root;
    logic signed [AngW-1:0] co_angle;
    logic signed [40:0] mu_prod;
    logic signed [15:0] sq_x, sq_y;
    reg_idx_t    widx;

    logic [28:0] lin_full;
    logic [14:0] lin_sat;
    logic signed [40:0] ang_full;
    logic signed [16:0] ang_sh, lim17;
    logic signed [15:0] ang_sat;
    logic at_wp;

    assign sq_x = phase_reg ? item_reg.start_dx : item_reg.wp_dx;
    assign sq_y = phase_reg ? item_reg.start_dy : item_reg.wp_dy;

    wplc_sqrt u_sqrt (
        .clk(clk), .rst_n(rst_n), .start(sq_start), .dx(sq_x), .dy(sq_y),
        .done(sq_done), .root(sq_root)
    );

    wplc_cordic u_cordic (
        .clk(clk), .rst_n(rst_n), .start(co_start), .dx(item_reg.wp_dx),
        .dy(item_reg.wp_dy), .done(co_done), .angle(co_angle)
    );

    wplc_mul u_mul (
        .clk(clk), .rst_n(rst_n), .start(mu_start), .gain(cfg_reg.angular_gain),
        .operand(ang_reg), .done(mu_done), .product(mu_prod)
    );

    // apb
    assign pready = 1'b1;
    assign widx   = reg_idx_t'(paddr[4:2]);

    always_comb
    begin
        unique case (widx)
            REG_LIN_GAIN:  prdata = {20'd0, cfg_reg.linear_gain};
            REG_MAX_LIN:   prdata = {17'd0, cfg_reg.fwd_rate_cap};
            REG_ANG_GAIN:  prdata = {20'd0, cfg_reg.angular_gain};
            REG_ANG_LIMIT: prdata = {17'd0, cfg_reg.angular_limit};
            REG_ARRIVE:    prdata = {17'd0, cfg_reg.arrive_radius};
            REG_LEAVE:     prdata = {17'd0, cfg_reg.leave_radius};
            REG_RETURN:    prdata = {17'd0, cfg_reg.return_radius};
            default:       prdata = '0;
        endcase
    end

    always_comb
    begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite)
        begin
            unique case (widx)
                REG_LIN_GAIN:  cfg_next.linear_gain      = pwdata[11:0];
                REG_MAX_LIN:   cfg_next.fwd_rate_cap     = pwdata[14:0];
                REG_ANG_GAIN:  cfg_next.angular_gain     = pwdata[11:0];
                REG_ANG_LIMIT: cfg_next.angular_limit    = pwdata[14:0];
                REG_ARRIVE:    cfg_next.arrive_radius    = pwdata[14:0];
                REG_LEAVE:     cfg_next.leave_radius     = pwdata[14:0];
                REG_RETURN:    cfg_next.return_radius    = pwdata[14:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    // wrap-up arithmetic
    assign lin_full = 29'({12'd0, wdist_reg} * {17'd0, cfg_reg.linear_gain}) + 29'd128;
    assign lin_sat  = (lin_full[28:8] > {6'd0, cfg_reg.fwd_rate_cap})
                      ? cfg_reg.fwd_rate_cap : lin_full[22:8];
    assign ang_full = prod_reg + 41'sd8388608;
    assign ang_sh   = ang_full[40:24];
    assign lim17    = $signed({2'b00, cfg_reg.angular_limit});
    assign ang_sat  = (ang_sh > lim17) ? 16'(lim17) :
                      (ang_sh < -lim17) ? 16'(-lim17) : 16'(ang_sh);
    assign at_wp    = wdist_reg < {2'd0, cfg_reg.arrive_radius};

    assign in_ready  = (st_reg == ST_IDLE);
    assign out_valid = (st_reg == ST_OUT);
    assign out_data  = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= ST_IDLE;
            cfg_reg   <= '{linear_gain: 12'd128, fwd_rate_cap: 15'd128,
                           angular_gain: 12'd512, angular_limit: 15'd256,
                           arrive_radius: 15'd26, leave_radius: 15'd128,
                           return_radius: 15'd77};
            flag_reg  <= 1'b0;
            goal_reg  <= GOAL_RUNNING;
            phase_reg <= 1'b0;
            kick_reg  <= 1'b0;
        end
        else
        begin
            st_reg    <= st_next;
            cfg_reg   <= cfg_next;
            flag_reg  <= flag_next;
            goal_reg  <= goal_next;
            phase_reg <= phase_next;
            kick_reg  <= kick_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        res_reg   <= res_next;
        wdist_reg <= wdist_next;
        sdist_reg <= sdist_next;
        ang_reg   <= ang_next;
        prod_reg  <= prod_next;
    end

    always_comb
    begin
        st_next    = st_reg;
        flag_next  = flag_reg;
        goal_next  = goal_reg;
        phase_next = phase_reg;
        kick_next  = 1'b0;
        item_next  = item_reg;
        res_next   = res_reg;
        wdist_next = wdist_reg;
        sdist_next = sdist_reg;
        ang_next   = ang_reg;
        prod_next  = prod_reg;
        sq_start   = 1'b0;
        co_start   = 1'b0;
        mu_start   = 1'b0;
        unique case (st_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    item_next = in_data;
                    res_next  = '0;
                    if (cmd_t'(in_data.command) == CMD_SAMPLE)
                    begin
                        phase_next = 1'b0;
                        kick_next  = 1'b1;
                        st_next    = ST_SQRT;
                    end
                    else
                    begin
                        unique case (cmd_t'(in_data.command))
                            CMD_RESTART:
                            begin
                                flag_next = 1'b0;
                                goal_next = GOAL_RUNNING;
                            end
                            CMD_CANCEL:
                                if (goal_reg == GOAL_RUNNING) goal_next = GOAL_CANCELED;
                            default: ;
                        endcase
                        res_next.start_left  = flag_next;
                        res_next.goal_status = goal_next;
                        st_next = ST_OUT;
                    end
                end
            end
            ST_SQRT:
            begin
                // units start on the registered item; second magnitude the cycle after sq_done
                sq_start = kick_reg;
                co_start = kick_reg && !phase_reg;
                if (co_done)
                    ang_next = co_angle;
                if (sq_done)
                begin
                    if (!phase_reg)
                    begin
                        wdist_next = sq_root;
                        phase_next = 1'b1;
                        kick_next  = 1'b1;
                    end
                    else
                    begin
                        sdist_next = sq_root;
                        st_next    = ST_CORDIC;
                    end
                end
            end
            ST_CORDIC:
            begin
                // zero vector gives zero bearing
                if (item_reg.wp_dx == 16'sd0 && item_reg.wp_dy == 16'sd0)
                    ang_next = '0;
                st_next = ST_MUL;
            end
            ST_MUL:
            begin
                if (phase_reg)
                begin
                    mu_start   = 1'b1;
                    phase_next = 1'b0;
                end
                else if (mu_done)
                begin
                    prod_next = mu_prod;
                    st_next   = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                res_next.waypoint_distance = wdist_reg[16] ? 16'hFFFF : wdist_reg[15:0];
                res_next.at_waypoint       = at_wp;
                if (goal_reg == GOAL_RUNNING)
                begin
                    res_next.fwd_rate  = at_wp ? 15'd0 : lin_sat;
                    res_next.turn_rate = at_wp ? 16'sd0 : ang_sat;
                    flag_next = flag_reg || (sdist_reg > {2'd0, cfg_reg.leave_radius});
                    if (flag_next && sdist_reg < {2'd0, cfg_reg.return_radius})
                    begin
                        goal_next = GOAL_DONE;
                        res_next.fwd_rate  = '0;
                        res_next.turn_rate = '0;
                    end
                end
                res_next.start_left  = flag_next;
                res_next.goal_status = goal_next;
                st_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_ready)
                    st_next = ST_IDLE;
            end
            default: st_next = ST_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid)) else $error("input and output open together");
    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.goal_status == GOAL_DONE) |-> out_data.fwd_rate == 15'd0)
        else $error("drive on completed lap");
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
`endif

endmodule

>>> hw/rtl/wplc_sqrt.sv
// magnitude: squares by shift-add one bit a cycle, then a restoring root two bits a cycle
module wplc_sqrt
    import wplc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [15:0] dx,
    input  logic signed [15:0] dy,
    output logic               done,
    output logic [16:0]        root
);

    sq_state_t   st_reg, st_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [15:0] ax_reg, ax_next, ay_reg, ay_next;
    logic [15:0] mx_reg, mx_next, my_reg, my_next;
    logic [32:0] n_reg, n_next;
    logic [32:0] nsh_reg, nsh_next;
    logic [18:0] rem_reg, rem_next;
    logic [16:0] r_reg, r_next;
    logic [18:0] trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= SQ_IDLE;
            cnt_reg <= '0;
        end
        else
        begin
            st_reg  <= st_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ax_reg  <= ax_next;
        ay_reg  <= ay_next;
        mx_reg  <= mx_next;
        my_reg  <= my_next;
        n_reg   <= n_next;
        nsh_reg <= nsh_next;
        rem_reg <= rem_next;
        r_reg   <= r_next;
    end

    assign trial = {rem_reg[16:0], nsh_reg[32:31]} - {r_reg, 2'b01};

    always_comb
    begin
        st_next  = st_reg;
        cnt_next = cnt_reg;
        ax_next  = ax_reg;
        ay_next  = ay_reg;
        mx_next  = mx_reg;
        my_next  = my_reg;
        n_next   = n_reg;
        nsh_next = nsh_reg;
        rem_next = rem_reg;
        r_next   = r_reg;
        done     = 1'b0;
        unique case (st_reg)
            SQ_IDLE:
            begin
                if (start)
                begin
                    ax_next  = dx[15] ? 16'(-dx) : 16'(dx);
                    ay_next  = dy[15] ? 16'(-dy) : 16'(dy);
                    mx_next  = dx[15] ? 16'(-dx) : 16'(dx);
                    my_next  = dy[15] ? 16'(-dy) : 16'(dy);
                    n_next   = '0;
                    cnt_next = 5'd0;
                    st_next  = SQ_MUL;
                end
            end
            SQ_MUL:
            begin
                // one multiplier bit of each square per cycle
                n_next = n_reg;
                if (mx_reg[0]) n_next = n_next + ({17'd0, ax_reg} << cnt_reg);
                if (my_reg[0]) n_next = n_next + ({17'd0, ay_reg} << cnt_reg);
                mx_next  = mx_reg >> 1;
                my_next  = my_reg >> 1;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd15)
                begin
                    // sum of squares fits 32 bits, so pairs line up from bit 31
                    nsh_next = {n_next[31:0], 1'b0};
                    rem_next = '0;
                    r_next   = '0;
                    cnt_next = 5'd0;
                    st_next  = SQ_ROOT;
                end
            end
            SQ_ROOT:
            begin
                if (!trial[18])
                begin
                    rem_next = trial;
                    r_next   = {r_reg[15:0], 1'b1};
                end
                else
                begin
                    rem_next = {rem_reg[16:0], nsh_reg[32:31]};
                    r_next   = {r_reg[15:0], 1'b0};
                end
                nsh_next = {nsh_reg[30:0], 2'b00};
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd15)
                    st_next = SQ_RND;
            end
            SQ_RND:
            begin
                st_next = SQ_IDLE;
                done    = 1'b1;
            end
            default: st_next = SQ_IDLE;
        endcase
    end

    // round to nearest: the remainder n - r*r against r
    assign root = (st_reg == SQ_RND && rem_reg > {2'd0, r_reg}) ? r_reg + 17'd1 : r_reg;

endmodule

>>> hw/rtl/wplc_cordic.sv
// vectoring cordic, one rotation per cycle
module wplc_cordic
    import wplc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic signed [15:0]     dx,
    input  logic signed [15:0]     dy,
    output logic                   done,
    output logic signed [AngW-1:0] angle
);

    logic               busy_reg, busy_next;
    logic [4:0]         i_reg, i_next;
    logic signed [34:0] x_reg, x_next, y_reg, y_next;
    logic signed [AngW-1:0] z_reg, z_next;
    logic signed [34:0] xs, ys;
    logic signed [AngW-1:0] at;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            i_reg    <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            i_reg    <= i_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign xs = x_reg >>> i_reg;
    assign ys = y_reg >>> i_reg;
    assign at = $signed(atan_entry(i_reg));

    always_comb
    begin
        busy_next = busy_reg;
        i_next    = i_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        done      = 1'b0;
        if (!busy_reg)
        begin
            if (start)
            begin
                x_next = {{3{dx[15]}}, dx, 16'd0};
                y_next = {{3{dy[15]}}, dy, 16'd0};
                z_next = '0;
                if (dx[15])
                begin
                    z_next = dy[15] ? -AngPi : AngPi;
                    x_next = -{{3{dx[15]}}, dx, 16'd0};
                    y_next = -{{3{dy[15]}}, dy, 16'd0};
                end
                i_next    = '0;
                busy_next = 1'b1;
            end
        end
        else
        begin
            if (y_reg > 0)
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + at;
            end
            else
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - at;
            end
            i_next = i_reg + 5'd1;
            if (i_reg == 5'(CordicIterations - 1))
            begin
                busy_next = 1'b0;
                done      = 1'b1;
            end
        end
    end

    // angle includes the last rotation in the done cycle
    assign angle = z_next;

endmodule

>>> hw/rtl/wplc_mul.sv
// shift-add multiplier, one bit of the gain per cycle
module wplc_mul
    import wplc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [11:0]        gain,
    input  logic signed [AngW-1:0] operand,
    output logic               done,
    output logic signed [40:0] product
);

    logic               busy_reg, busy_next;
    logic [3:0]         cnt_reg, cnt_next;
    logic [11:0]        g_reg, g_next;
    logic signed [40:0] acc_reg, acc_next;
    logic signed [40:0] op_reg, op_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        g_reg   <= g_next;
        acc_reg <= acc_next;
        op_reg  <= op_next;
    end

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        g_next    = g_reg;
        acc_next  = acc_reg;
        op_next   = op_reg;
        done      = 1'b0;
        if (!busy_reg)
        begin
            if (start)
            begin
                g_next    = gain;
                acc_next  = '0;
                op_next   = 41'(operand);
                cnt_next  = '0;
                busy_next = 1'b1;
            end
        end
        else
        begin
            if (g_reg[0])
                acc_next = acc_reg + op_reg;
            g_next   = g_reg >> 1;
            op_next  = op_reg <<< 1;
            cnt_next = cnt_reg + 4'd1;
            if (cnt_reg == 4'd11)
            begin
                busy_next = 1'b0;
                done      = 1'b1;
            end
        end
    end

    // product includes the top gain bit in the done cycle
    assign product = acc_next;

endmodule

>>> bench/wplc_checker.sv
module wplc_checker
    import wplc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_ready,
    input  in_item_t  in_data,
    input  logic      out_valid,
    input  logic      out_ready,
    input  out_item_t out_data,
    input  logic      psel,
    input  logic      penable,
    input  logic      pwrite,
    input  logic [4:0] paddr,
    input  logic [31:0] pwdata,
    output int        fail_count,
    output int        pending_count
);

    cfg_t      cfg;
    logic      lap_left;
    goal_t     lap_goal;
    out_item_t drive_queue[$];

    localparam longint HalfTurn = 64'sd52707179;

    function automatic longint arctan_step(input int i);
        longint t[8] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123,
                         131069};
        if (i < 8)
            return t[i];
        return longint'(65536) >>> (i - 8);
    endfunction

    function automatic longint shr_floor(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint isqrt_round(input longint dx, input longint dy);
        longint n;
        longint r;
        n = dx * dx + dy * dy;
        r = 0;
        for (int b = 31; b >= 0; b--)
        begin
            if ((r + (longint'(1) << b)) * (r + (longint'(1) << b)) <= n)
                r = r + (longint'(1) << b);
        end
        if (n - r * r > r)
            r++;
        return r;
    endfunction

    function automatic longint heading(input longint dx, input longint dy);
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        x = dx * 65536;
        y = dy * 65536;
        z = 0;
        if (dx == 0 && dy == 0)
            return 0;
        if (x < 0)
        begin
            z = (y >= 0) ? HalfTurn : -HalfTurn;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < CordicIterations; i++)
        begin
            xs = shr_floor(x, i);
            ys = shr_floor(y, i);
            if (y > 0)
            begin
                x += ys; y -= xs; z += arctan_step(i);
            end
            else
            begin
                x -= ys; y += xs; z -= arctan_step(i);
            end
        end
        return z;
    endfunction

    function automatic out_item_t steer(input in_item_t it);
        out_item_t o;
        longint    d;
        longint    sd;
        longint    lin;
        longint    ang;
        longint    lim;
        o = '0;
        lin = 0;
        ang = 0;
        if (cmd_t'(it.command) == CMD_SAMPLE)
        begin
            d = isqrt_round(longint'(it.wp_dx), longint'(it.wp_dy));
            sd = isqrt_round(longint'(it.start_dx), longint'(it.start_dy));
            o.at_waypoint = d < cfg.arrive_radius;
            if (lap_goal == GOAL_RUNNING)
            begin
                lim = cfg.angular_limit;
                lin = (cfg.linear_gain * d + 128) >>> 8;
                if (lin > cfg.fwd_rate_cap)
                    lin = cfg.fwd_rate_cap;
                ang = (longint'(cfg.angular_gain) * heading(it.wp_dx, it.wp_dy)
                       + (longint'(1) << 23)) >>> 24;
                if (ang > lim) ang = lim;
                if (ang < -lim) ang = -lim;
                if (o.at_waypoint)
                begin
                    lin = 0; ang = 0;
                end
                if (sd > cfg.leave_radius)
                    lap_left = 1'b1;
                if (lap_left && sd < cfg.return_radius)
                begin
                    lap_goal = GOAL_DONE;
                    lin = 0; ang = 0;
                end
            end
            o.waypoint_distance = (d > 65535) ? 16'hffff : d[15:0];
        end
        else if (cmd_t'(it.command) == CMD_RESTART)
        begin
            lap_left = 1'b0;
            lap_goal = GOAL_RUNNING;
        end
        else if (cmd_t'(it.command) == CMD_CANCEL)
        begin
            if (lap_goal == GOAL_RUNNING)
                lap_goal = GOAL_CANCELED;
        end
        o.fwd_rate = lin[14:0];
        o.turn_rate = ang[15:0];
        o.start_left = lap_left;
        o.goal_status = lap_goal;
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            cfg.linear_gain <= 12'd128;
            cfg.fwd_rate_cap <= 15'd128;
            cfg.angular_gain <= 12'd512;
            cfg.angular_limit <= 15'd256;
            cfg.arrive_radius <= 15'd26;
            cfg.leave_radius <= 15'd128;
            cfg.return_radius <= 15'd77;
            lap_left = 1'b0;
            lap_goal = GOAL_RUNNING;
            fail_count <= 0;
            pending_count <= 0;
            drive_queue.delete();
        end
        else
        begin
            if (psel && penable && pwrite)
            begin
                case (reg_idx_t'(paddr[4:2]))
                    REG_LIN_GAIN:  cfg.linear_gain <= pwdata[11:0];
                    REG_MAX_LIN:   cfg.fwd_rate_cap <= pwdata[14:0];
                    REG_ANG_GAIN:  cfg.angular_gain <= pwdata[11:0];
                    REG_ANG_LIMIT: cfg.angular_limit <= pwdata[14:0];
                    REG_ARRIVE:    cfg.arrive_radius <= pwdata[14:0];
                    REG_LEAVE:     cfg.leave_radius <= pwdata[14:0];
                    REG_RETURN:    cfg.return_radius <= pwdata[14:0];
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (drive_queue.size() == 0)
                begin
                    $display("%0t: unexpected item %h", $time, out_data);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = drive_queue.pop_front();
                    if (want !== out_data)
                    begin
                        $display("%0t: mismatch expected %h actual %h", $time, want, out_data);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (in_valid && in_ready)
                drive_queue.push_back(steer(in_data));
            pending_count <= drive_queue.size();
        end
    end

endmodule

>>> bench/waypoint_pursuit_lap_controller_test.sv
module waypoint_pursuit_lap_controller_test;
    import wplc_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_ready;
    out_item_t   out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending_count;
    int          sent;

    waypoint_pursuit_lap_controller dut (.*);
    wplc_checker lap_check (.*);

    always
    begin
        clk = 1'b1; #10;
        clk = 1'b0; #10;
    end

    // receiver stall pattern, keyed to the sender's item count: always ready in every third block of 200 items
    always @(negedge clk)
    begin
        if ((sent / 200) % 3 == 1)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(0, 3) != 0);
    end

    task automatic send_item(input in_item_t it);
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        in_valid <= 1'b0;
        sent++;
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 60)) @(negedge clk);
        @(negedge clk);
    endtask

    task automatic drain;
        while (pending_count != 0)
            @(negedge clk);
        repeat (80) @(negedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [31:0] v);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= v;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic signed [15:0] rand_pos(input int span);
        case ($urandom_range(0, 5))
            0: return 16'($urandom);
            1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            default: return $signed(16'($urandom_range(0, 2 * span))) - 16'(span);
        endcase
    endfunction

    function automatic in_item_t make_sample(input int span);
        in_item_t it;
        it.command = CMD_SAMPLE;
        it.wp_dx = rand_pos(span);
        it.wp_dy = rand_pos(span);
        it.start_dx = rand_pos(span);
        it.start_dy = rand_pos(span);
        return it;
    endfunction

    task automatic send_cmd(input cmd_t c, input logic signed [15:0] wx,
                            input logic signed [15:0] wy, input logic signed [15:0] sx,
                            input logic signed [15:0] sy);
        in_item_t it;
        it = '{command: c, wp_dx: wx, wp_dy: wy, start_dx: sx, start_dy: sy};
        send_item(it);
    endtask

    task automatic set_all(input logic [11:0] lg, input logic [14:0] ml,
                           input logic [11:0] ag, input logic [14:0] al,
                           input logic [14:0] ar, input logic [14:0] lr,
                           input logic [14:0] rr);
        write_reg(REG_LIN_GAIN, 32'(lg));
        write_reg(REG_MAX_LIN, 32'(ml));
        write_reg(REG_ANG_GAIN, 32'(ag));
        write_reg(REG_ANG_LIMIT, 32'(al));
        write_reg(REG_ARRIVE, 32'(ar));
        write_reg(REG_LEAVE, 32'(lr));
        write_reg(REG_RETURN, 32'(rr));
    endtask

    initial
    begin
        #60000000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        in_item_t it;
        int span;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        sent = 0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: extremes, zero vector, negative forward offset, lap sequence
        send_cmd(CMD_SAMPLE, 0, 0, 0, 0);
        send_cmd(CMD_SAMPLE, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000);
        send_cmd(CMD_SAMPLE, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff);
        send_cmd(CMD_SAMPLE, -300, 0, 300, 0);
        send_cmd(CMD_SAMPLE, -300, -1, 0, 0);
        send_cmd(CMD_SAMPLE, 5, 3, 10, 0);
        send_cmd(CMD_SAMPLE, 0, 400, 20, 0);
        send_cmd(CMD_SAMPLE, 400, 0, 20, 0);
        send_cmd(CMD_CANCEL, 0, 0, 0, 0);
        send_cmd(CMD_CANCEL, 0, 0, 0, 0);
        send_cmd(CMD_UNUSED, 16'sh7fff, 1, 2, 3);
        send_cmd(CMD_RESTART, 0, 0, 0, 0);
        send_cmd(CMD_SAMPLE, 500, -500, 1000, 0);
        send_cmd(CMD_SAMPLE, 100, 100, 0, 0);
        send_cmd(CMD_SAMPLE, 100, 100, 0, 0);
        send_cmd(CMD_CANCEL, 0, 0, 0, 0);
        send_cmd(CMD_RESTART, 0, 0, 0, 0);
        drain();

        // leave and return together with return above leave
        set_all(12'd4095, 15'd32767, 12'd4095, 15'd32767, 15'd0, 15'd10, 15'd32767);
        send_cmd(CMD_SAMPLE, -20000, 20000, 20, 0);
        send_cmd(CMD_RESTART, 0, 0, 0, 0);
        send_cmd(CMD_SAMPLE, -20000, -20000, 5, 0);
        drain();

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: set_all(12'd0, 15'd0, 12'd0, 15'd0, 15'd32767, 15'd32767, 15'd0);
                1: set_all(12'd128, 15'd128, 12'd512, 15'd256, 15'd26, 15'd128, 15'd77);
                2: set_all(12'd4095, 15'd32767, 12'd4095, 15'd32767, 15'd0, 15'd0, 15'd0);
                default: set_all(12'($urandom), 15'($urandom), 12'($urandom), 15'($urandom),
                                 15'($urandom_range(0, 200)), 15'($urandom_range(0, 2000)),
                                 15'($urandom_range(0, 1500)));
            endcase
            span = (phase % 2) ? 3000 : 600;
            for (int n = 0; n < 255; n++)
            begin
                case ($urandom_range(0, 19))
                    0: send_cmd(CMD_RESTART, 16'($urandom), 16'($urandom), 16'($urandom),
                                16'($urandom));
                    1: send_cmd(CMD_CANCEL, 16'($urandom), 16'($urandom), 16'($urandom),
                                16'($urandom));
                    2: send_cmd(CMD_UNUSED, 16'($urandom), 16'($urandom), 16'($urandom),
                                16'($urandom));
                    default:
                    begin
                        it = make_sample(span);
                        send_item(it);
                    end
                endcase
            end
            drain();
        end

        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/wplc_pkg.sv
hw/rtl/wplc_sqrt.sv
hw/rtl/wplc_cordic.sv
hw/rtl/wplc_mul.sv
hw/rtl/waypoint_pursuit_lap_controller.sv
bench/wplc_checker.sv
bench/waypoint_pursuit_lap_controller_test.sv
